@@ rtl/utf16_to_utf8_encoder_macros.svh @@
// Assertion macros shared by the encoder RTL.
// Used inside modules of the utf16_to_utf8_encoder block; depends on nothing else.
`ifndef UTF16_TO_UTF8_ENCODER_MACROS_SVH
`define UTF16_TO_UTF8_ENCODER_MACROS_SVH

// Same-cycle implication, checked while reset is low.
`define U16U8_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked while reset is low.
`define U16U8_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/u16u8_pkg.sv @@
// Types, constants and byte-encoding functions for the UTF-16 to UTF-8 encoder.
// Depends on nothing; used by every module of the block.
package u16u8_pkg;

   localparam logic [15:0] SURR_MASK = 16'hFC00;
   localparam logic [15:0] HIGH_SURR = 16'hD800;
   localparam logic [15:0] LOW_SURR  = 16'hDC00;
   localparam logic [20:0] SUPP_BASE = 21'h10000;
   localparam logic [2:0]  FLUSH_LEN = 3'd3;

   // What the main part of a job does.
   typedef enum logic {
      JOB_ENCODE = 1'b0,
      JOB_END    = 1'b1
   } job_kind_type;

   // One classified input word: an optional flushed lone high surrogate,
   // then an optional main part.
   typedef struct packed {
      logic         flush;
      logic [9:0]   flush_bits;
      logic         main_valid;
      job_kind_type kind;
      logic [20:0]  point;
   } job_type;

   // Number of UTF-8 bytes for a code point.
   function automatic logic [2:0] utf8_len(input logic [20:0] c);
      logic [2:0] n;
      if (c < 21'h80) begin
         n = 3'd1;
      end else if (c < 21'h800) begin
         n = 3'd2;
      end else if (c < SUPP_BASE) begin
         n = 3'd3;
      end else begin
         n = 3'd4;
      end
      return n;
   endfunction

   // Byte number pos of the len-byte UTF-8 form of c.
   function automatic logic [7:0] utf8_byte(input logic [20:0] c, input logic [2:0] len,
                                            input logic [1:0] pos);
      logic [7:0] b;
      b = 8'h00;
      unique case (len)
         3'd1: b = c[7:0];
         3'd2: begin
            if (pos == 2'd0) begin
               b = {3'b110, c[10:6]};
            end else begin
               b = {2'b10, c[5:0]};
            end
         end
         3'd3: begin
            unique case (pos)
               2'd0:    b = {4'b1110, c[15:12]};
               2'd1:    b = {2'b10, c[11:6]};
               default: b = {2'b10, c[5:0]};
            endcase
         end
         3'd4: begin
            unique case (pos)
               2'd0: b = {5'b11110, c[20:18]};
               2'd1: b = {2'b10, c[17:12]};
               2'd2: b = {2'b10, c[11:6]};
               2'd3: b = {2'b10, c[5:0]};
            endcase
         end
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

@@ rtl/u16u8_front.sv @@
// Front end: accepts UTF-16 words, tracks the pending high surrogate and
// turns each word into a job for the queue. Depends on u16u8_pkg.
module u16u8_front import u16u8_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [15:0] req_code_unit,
   output logic        req_full,
   output logic        q_push,
   output job_type     q_job,
   input  logic        q_full
);

   logic       pend_valid_ff, pend_valid_in;
   logic [9:0] pend_bits_ff, pend_bits_in;
   logic       accept;
   logic       is_high, is_low, is_zero;
   job_type    job;

   assign accept  = req_push && !q_full;
   assign is_high = (req_code_unit & SURR_MASK) == HIGH_SURR;
   assign is_low  = (req_code_unit & SURR_MASK) == LOW_SURR;
   assign is_zero = req_code_unit == 16'h0000;

   // Classify the incoming word against the pending surrogate.
   always_comb begin
      job           = '0;
      job.kind      = JOB_ENCODE;
      pend_valid_in = pend_valid_ff;
      pend_bits_in  = pend_bits_ff;
      job.flush_bits = pend_bits_ff;
      if (pend_valid_ff && is_low) begin
         job.main_valid = 1'b1;
         job.point      = {1'b0, pend_bits_ff, req_code_unit[9:0]} + SUPP_BASE;
         pend_valid_in  = 1'b0;
      end else begin
         job.flush = pend_valid_ff;
         if (is_high) begin
            pend_valid_in = 1'b1;
            pend_bits_in  = req_code_unit[9:0];
         end else if (is_zero) begin
            pend_valid_in  = 1'b0;
            job.main_valid = 1'b1;
            job.kind       = JOB_END;
         end else begin
            pend_valid_in  = 1'b0;
            job.main_valid = 1'b1;
            job.point      = {5'b0, req_code_unit};
         end
      end
   end

   // Surrogate state advances on every accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         pend_bits_ff  <= '0;
      end else if (accept) begin
         pend_valid_ff <= pend_valid_in;
         pend_bits_ff  <= pend_bits_in;
      end
   end

   // A word that only becomes pending makes no job.
   assign q_push   = accept && (job.flush || job.main_valid);
   assign q_job    = job;
   assign req_full = q_full;

endmodule

@@ rtl/u16u8_jobq.sv @@
// Short job queue between the front end and the byte sequencer.
// Depends on u16u8_pkg.
module u16u8_jobq import u16u8_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type head_job,
   output logic    empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   job_type           mem_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]   count_ff;
   logic              do_push, do_pop;

   assign full     = count_ff == CntW'(DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = mem_ff[rd_ptr_ff];

   // Storage write.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

@@ rtl/u16u8_back.sv @@
// Back end: walks the head job one UTF-8 byte per cycle unless stalled, keeps the string
// byte count and holds the result word in an output register. Depends on u16u8_pkg.
`include "utf16_to_utf8_encoder_macros.svh"
module u16u8_back import u16u8_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  job_type     head_job,
   input  logic        q_empty,
   output logic        q_pop,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run,
   output logic        rsp_string_end,
   output logic [15:0] rsp_bytes_so_far
);

   logic [2:0]  idx_ff;
   logic [2:0]  n_flush, n_main, total, len_sel;
   logic [1:0]  pos;
   logic [20:0] point_sel;
   logic        in_flush, is_last, is_end, fire;
   logic [7:0]  byte_val;
   logic [15:0] count_ff, count_inc;
   logic        out_valid_ff;
   logic [7:0]  out_byte_ff;
   logic        out_last_ff, out_end_ff;
   logic [15:0] out_count_ff;

   // Byte counts of the two parts of the head job.
   always_comb begin
      n_flush = head_job.flush ? FLUSH_LEN : 3'd0;
      if (!head_job.main_valid) begin
         n_main = 3'd0;
      end else if (head_job.kind == JOB_END) begin
         n_main = 3'd1;
      end else begin
         n_main = utf8_len(head_job.point);
      end
      total = n_flush + n_main;
   end

   // Pick the byte under the cursor.
   always_comb begin
      in_flush = idx_ff < n_flush;
      if (in_flush) begin
         point_sel = {5'b0, 6'b110110, head_job.flush_bits};
         len_sel   = FLUSH_LEN;
         pos       = idx_ff[1:0];
      end else begin
         point_sel = head_job.point;
         len_sel   = n_main;
         pos       = 2'(idx_ff - n_flush);
      end
      is_end   = !in_flush && (head_job.kind == JOB_END);
      byte_val = is_end ? 8'h00 : utf8_byte(point_sel, len_sel, pos);
      is_last  = idx_ff == total - 3'd1;
   end

   assign fire      = !q_empty && (!out_valid_ff || rsp_pop);
   assign q_pop     = fire && is_last;
   assign count_inc = (count_ff == 16'hFFFF) ? count_ff : count_ff + 16'd1;

   // Cursor and string byte count.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         count_ff <= '0;
      end else if (fire) begin
         idx_ff   <= is_last ? 3'd0 : idx_ff + 3'd1;
         count_ff <= is_end ? 16'd0 : count_inc;
      end
   end

   // Output register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (fire) begin
         out_byte_ff  <= byte_val;
         out_last_ff  <= is_last;
         out_end_ff   <= is_end;
         out_count_ff <= count_inc;
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_last_of_run  = out_last_ff;
   assign rsp_string_end   = out_end_ff;
   assign rsp_bytes_so_far = out_count_ff;

   `U16U8_ASSERT_NOW(a_cursor_in_job, clock, reset, !q_empty, idx_ff < total,
      "byte cursor ran past the head job")
   `U16U8_ASSERT_NOW(a_cursor_needs_job, clock, reset, idx_ff != 3'd0, !q_empty,
      "byte cursor advanced with no job queued")
   `U16U8_ASSERT_NOW(a_end_is_zero, clock, reset, out_valid_ff && out_end_ff,
      out_byte_ff == 8'h00 && out_last_ff, "string end word is not a final zero byte")
   `U16U8_ASSERT_NEXT(a_word_held, clock, reset, out_valid_ff && !rsp_pop, out_valid_ff,
      "result word dropped while stalled")

endmodule

@@ rtl/utf16_to_utf8_encoder.sv @@
// UTF-16 to UTF-8 encoder, one code unit in and one UTF-8 byte out per word.
// Usage:
//   Input: drive req_code_unit and raise req_push; the word is taken at a clock
//   edge with req_full low. A zero unit ends the string.
//   Output: while rsp_empty is low, the oldest byte is on rsp_out_byte with
//   rsp_last_of_run, rsp_string_end and rsp_bytes_so_far; raise rsp_pop to take it.
// A taken word is written to the job queue, then its bytes to the output register.
// Bytes: the byte sequencer sends one byte per cycle unless the output stalls;
//   a word yields one to three bytes for a plain unit, four for a surrogate
//   pair, plus three more when a lone high surrogate is flushed.
//   A high surrogate alone yields nothing until its successor arrives.
// The job queue between front end and sequencer holds QUEUE_DEPTH words, so
//   the front end keeps taking words while the sequencer is busy or stalled.
// Reset clears the pending surrogate, the byte count and all queued work.
// When rsp_pop stays low, the output word holds, the queue fills and req_full
//   rises; nothing is lost.
// Depends on u16u8_pkg, u16u8_front, u16u8_jobq and u16u8_back.
module utf16_to_utf8_encoder import u16u8_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [15:0] req_code_unit,
   output logic        req_full,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run,
   output logic        rsp_string_end,
   output logic [15:0] rsp_bytes_so_far
);

   logic    q_push, q_full, q_pop, q_empty;
   job_type q_in_job, q_head_job;

   // Classification and surrogate tracking.
   u16u8_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_code_unit (req_code_unit),
      .req_full      (req_full),
      .q_push        (q_push),
      .q_job         (q_in_job),
      .q_full        (q_full)
   );

   // Decoupling queue.
   u16u8_jobq #(
      .DEPTH (QUEUE_DEPTH)
   ) u_jobq (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_in_job),
      .full     (q_full),
      .pop      (q_pop),
      .head_job (q_head_job),
      .empty    (q_empty)
   );

   // Byte sequencer and output register.
   u16u8_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_job         (q_head_job),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_string_end   (rsp_string_end),
      .rsp_bytes_so_far (rsp_bytes_so_far)
   );

endmodule
